### rtl/core/two_pool_slot_allocator_core_macros.svh
// assertion macros for the two-pool slot allocator core
// used by modules that check their own control logic; expects aclk and aresetn in scope
`ifndef TWO_POOL_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define TWO_POOL_SLOT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TPSA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TPSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tpsa_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the two-pool slot allocator
// no dependencies
package tpsa_pkg;

    // pool sizes
    localparam int SMALL_SLOTS = 256;
    localparam int LARGE_SLOTS = 4096;

    // field widths
    localparam int SLOT_W   = 12;
    localparam int STATUS_W = 3;
    localparam int CMP_W    = SLOT_W + 1;

    // per-pool stack index and counter widths
    localparam int SM_IDX_W = $clog2(SMALL_SLOTS);
    localparam int SM_CNT_W = $clog2(SMALL_SLOTS + 1);
    localparam int LG_IDX_W = $clog2(LARGE_SLOTS);
    localparam int LG_CNT_W = $clog2(LARGE_SLOTS + 1);

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_FROM_STACK = 3'd0,
        ST_FRESH      = 3'd1,
        ST_FULL       = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_IGNORED    = 3'd4,
        ST_DROPPED    = 3'd5
    } status_t;

    // operation and pool codes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;
    localparam logic POOL_SMALL = 1'b0;
    localparam logic POOL_LARGE = 1'b1;

    // stack memory requests
    typedef struct packed {
        logic                wr_en;
        logic [SM_IDX_W-1:0] wr_addr;
        logic [SM_IDX_W-1:0] wr_data;
        logic                rd_en;
        logic [SM_IDX_W-1:0] rd_addr;
    } sm_mem_req_t;

    typedef struct packed {
        logic                wr_en;
        logic [LG_IDX_W-1:0] wr_addr;
        logic [LG_IDX_W-1:0] wr_data;
        logic                rd_en;
        logic [LG_IDX_W-1:0] rd_addr;
    } lg_mem_req_t;

endpackage

### rtl/core/tpsa_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies
module tpsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/tpsa_ctrl.sv
`timescale 1ns / 1ps
// allocator control: high-water marks, free counts, sequencer and result register
// depends on tpsa_pkg and the assertion macro header
`include "two_pool_slot_allocator_core_macros.svh"

module tpsa_ctrl
    import tpsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // request transaction
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SLOT_W-1:0]   req_slot,
    input  logic                req_op,
    input  logic                req_pool,
    // result transaction
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [STATUS_W-1:0] res_status,
    output logic [SLOT_W-1:0]   res_slot,
    // stack memories
    output sm_mem_req_t         sm_req,
    input  logic [SM_IDX_W-1:0] sm_rd_data,
    output lg_mem_req_t         lg_req,
    input  logic [LG_IDX_W-1:0] lg_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic                pool_reg, pool_next;
    logic [SM_CNT_W-1:0] sm_hw_reg, sm_hw_next;
    logic [SM_CNT_W-1:0] sm_cnt_reg, sm_cnt_next;
    logic [LG_CNT_W-1:0] lg_hw_reg, lg_hw_next;
    logic [LG_CNT_W-1:0] lg_cnt_reg, lg_cnt_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;

    logic                s_fire;
    logic                sm_below_hw;
    logic                lg_below_hw;

    // accept only when idle and the result register is free or draining
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    // release range checks against the high-water marks
    assign sm_below_hw = CMP_W'(req_slot) < CMP_W'(sm_hw_reg);
    assign lg_below_hw = CMP_W'(req_slot) < CMP_W'(lg_hw_reg);

    // decision and sequencing
    always_comb begin
        state_next     = state_reg;
        pool_next      = pool_reg;
        sm_hw_next     = sm_hw_reg;
        sm_cnt_next    = sm_cnt_reg;
        lg_hw_next     = lg_hw_reg;
        lg_cnt_next    = lg_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        slot_next      = slot_reg;

        sm_req         = '0;
        sm_req.wr_addr = sm_cnt_reg[SM_IDX_W-1:0];
        sm_req.wr_data = req_slot[SM_IDX_W-1:0];
        sm_req.rd_addr = SM_IDX_W'(sm_cnt_reg - SM_CNT_W'(1));
        lg_req         = '0;
        lg_req.wr_addr = lg_cnt_reg[LG_IDX_W-1:0];
        lg_req.wr_data = req_slot[LG_IDX_W-1:0];
        lg_req.rd_addr = LG_IDX_W'(lg_cnt_reg - LG_CNT_W'(1));

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    pool_next      = req_pool;
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    if (req_op == OP_ALLOC) begin
                        if (req_pool == POOL_SMALL) begin
                            if (sm_cnt_reg != '0) begin
                                // pop: data returns next cycle
                                sm_cnt_next    = sm_cnt_reg - SM_CNT_W'(1);
                                sm_req.rd_en   = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end else if (sm_hw_reg != SM_CNT_W'(SMALL_SLOTS)) begin
                                status_next = ST_FRESH;
                                slot_next   = SLOT_W'(sm_hw_reg);
                                sm_hw_next  = sm_hw_reg + SM_CNT_W'(1);
                            end else begin
                                status_next = ST_FULL;
                            end
                        end else begin
                            if (lg_cnt_reg != '0) begin
                                lg_cnt_next    = lg_cnt_reg - LG_CNT_W'(1);
                                lg_req.rd_en   = 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = S_READ;
                            end else if (lg_hw_reg != LG_CNT_W'(LARGE_SLOTS)) begin
                                status_next = ST_FRESH;
                                slot_next   = SLOT_W'(lg_hw_reg);
                                lg_hw_next  = lg_hw_reg + LG_CNT_W'(1);
                            end else begin
                                status_next = ST_FULL;
                            end
                        end
                    end else begin
                        if (req_pool == POOL_SMALL) begin
                            if (!sm_below_hw) begin
                                status_next = ST_IGNORED;
                            end else if (sm_cnt_reg == SM_CNT_W'(SMALL_SLOTS)) begin
                                status_next = ST_DROPPED;
                            end else begin
                                // push onto the free stack
                                sm_req.wr_en = 1'b1;
                                sm_cnt_next  = sm_cnt_reg + SM_CNT_W'(1);
                                status_next  = ST_RELEASED;
                            end
                        end else begin
                            if (!lg_below_hw) begin
                                status_next = ST_IGNORED;
                            end else if (lg_cnt_reg == LG_CNT_W'(LARGE_SLOTS)) begin
                                status_next = ST_DROPPED;
                            end else begin
                                lg_req.wr_en = 1'b1;
                                lg_cnt_next  = lg_cnt_reg + LG_CNT_W'(1);
                                status_next  = ST_RELEASED;
                            end
                        end
                    end
                end
            end
            S_READ: begin
                // popped slot is on the memory output
                out_valid_next = 1'b1;
                status_next    = ST_FROM_STACK;
                slot_next      = (pool_reg == POOL_SMALL) ? SLOT_W'(sm_rd_data)
                                                          : SLOT_W'(lg_rd_data);
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            sm_hw_reg     <= '0;
            sm_cnt_reg    <= '0;
            lg_hw_reg     <= '0;
            lg_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sm_hw_reg     <= sm_hw_next;
            sm_cnt_reg    <= sm_cnt_next;
            lg_hw_reg     <= lg_hw_next;
            lg_cnt_reg    <= lg_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pool_reg   <= pool_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign res_status = status_reg;
    assign res_slot   = slot_reg;

    // checks
    `TPSA_ASSERT_IMPL(a_no_accept_in_read, state_reg == S_READ, !s_tready,
        "request accepted while a stack read is pending")
    `TPSA_ASSERT_IMPL(a_no_result_overrun, out_valid_reg && !m_tready, !s_tready,
        "request accepted while a stalled result waits")
    `TPSA_ASSERT_IMPL(a_sm_cnt_bound, 1'b1, sm_cnt_reg <= SM_CNT_W'(SMALL_SLOTS),
        "small free count above pool size")
    `TPSA_ASSERT_NEXT(a_lg_hw_monotonic, 1'b1, lg_hw_reg >= $past(lg_hw_reg),
        "large high-water mark went down")
    `TPSA_ASSERT_NEXT(a_read_gives_result, state_reg == S_READ, out_valid_reg,
        "stack pop produced no result")

endmodule

### rtl/core/two_pool_slot_allocator_core.sv
`timescale 1ns / 1ps
// two-pool slot allocator: ties the control to the two free-stack memories
// depends on tpsa_pkg, tpsa_ctrl and tpsa_ram
// result is registered; a pop from a free stack reads the stack memory first
// throughput: 1 transaction per cycle unless m_tready stalls or a pop is in progress
// reset: high-water marks, free counts and valids clear at once; stack memories
// are not cleared and the block is ready in the first cycle after reset
module two_pool_slot_allocator_core
    import tpsa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [11:0] slot, [15:12] zero
    input  logic [1:0]  s_tuser,  // [0] operation, [1] pool
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // [2:0] status, [14:3] granted_slot, [15] zero
);

    sm_mem_req_t         sm_req;
    lg_mem_req_t         lg_req;
    logic [SM_IDX_W-1:0] sm_rd_data;
    logic [LG_IDX_W-1:0] lg_rd_data;
    logic [STATUS_W-1:0] res_status;
    logic [SLOT_W-1:0]   res_slot;

    // control
    tpsa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_slot   (s_tdata[SLOT_W-1:0]),
        .req_op     (s_tuser[0]),
        .req_pool   (s_tuser[1]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res_status (res_status),
        .res_slot   (res_slot),
        .sm_req     (sm_req),
        .sm_rd_data (sm_rd_data),
        .lg_req     (lg_req),
        .lg_rd_data (lg_rd_data)
    );

    // small pool free stack
    tpsa_ram #(
        .WIDTH (SM_IDX_W),
        .DEPTH (SMALL_SLOTS)
    ) u_sm_stack (
        .aclk    (aclk),
        .wr_en   (sm_req.wr_en),
        .wr_addr (sm_req.wr_addr),
        .wr_data (sm_req.wr_data),
        .rd_en   (sm_req.rd_en),
        .rd_addr (sm_req.rd_addr),
        .rd_data (sm_rd_data)
    );

    // large pool free stack
    tpsa_ram #(
        .WIDTH (LG_IDX_W),
        .DEPTH (LARGE_SLOTS)
    ) u_lg_stack (
        .aclk    (aclk),
        .wr_en   (lg_req.wr_en),
        .wr_addr (lg_req.wr_addr),
        .wr_data (lg_req.wr_data),
        .rd_en   (lg_req.rd_en),
        .rd_addr (lg_req.rd_addr),
        .rd_data (lg_rd_data)
    );

    // result packing
    assign m_tdata = {1'b0, res_slot, res_status};

endmodule
